FILE: design/rau_pkg.sv
// Shared types, codes and constants of the rational arithmetic unit.
package rau_pkg;

    localparam int OPERAND_BITS_DEF = 16;
    localparam int RESULT_BITS = 33;
    localparam int ACTION_BITS = 3;
    localparam int CODE_BITS = 2;

    localparam logic [ACTION_BITS-1:0] ACT_ADD = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_SUB = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_MUL = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_DIV = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_CMP = 3'd4;

    localparam logic [CODE_BITS-1:0] CMP_EQUAL = 2'd0;
    localparam logic [CODE_BITS-1:0] CMP_LESS = 2'd1;
    localparam logic [CODE_BITS-1:0] CMP_GREATER = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_FORM,
        ST_GCD_CHK,
        ST_GCD_WAIT,
        ST_NUM_START,
        ST_NUM_WAIT,
        ST_DEN_START,
        ST_DEN_WAIT,
        ST_DONE
    } rau_state_t;

    typedef enum logic [1:0] {
        DSEL_GCD,
        DSEL_NUM,
        DSEL_DEN
    } rau_dsel_t;

    typedef struct packed {
        logic       load;
        logic [1:0] mul_step;
        logic       mul_en;
        logic       form;
        logic       div_start;
        rau_dsel_t  div_sel;
        logic       gcd_update;
        logic       num_update;
        logic       den_update;
        logic       out_load;
    } rau_cmd_t;

    typedef struct packed {
        logic skip;
        logic x_zero;
        logic div_done;
        logic div_busy;
        logic out_free;
    } rau_status_t;

endpackage

FILE: design/rational_arithmetic_unit_top.sv
// Top level of the rational arithmetic unit with gcd reduction.
//
// Channel  Dir  Signals                  Payload, lowest bit first
// s_*      in   s_tvalid s_tready s_tdata action, a, b, c, d
// m_*      out  m_tvalid m_tready m_tdata numerator, denominator, compare code
//
// One item at a time: products in states ST_MUL0, ST_MUL1 and ST_MUL2 on one shared multiplier,
// a combine step, then Euclid steps on the serial divider and two more such divisions;
// compare and trivial cases skip the divisions and finish after the combine step.
// Reset clears the controller and the result valid flag; no clearing pass is needed.
// A waiting result sits in the output register while the next item can be accepted.
module rational_arithmetic_unit_top
    import rau_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // action, first_numerator, first_denominator, second_numerator, second_denominator
    input  logic [((ACTION_BITS + 4 * OPERAND_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // result_numerator, result_denominator, compare_code
    output logic [((2 * RESULT_BITS + CODE_BITS + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int OB = OPERAND_BITS;
    localparam int OUT_W = ((2 * RESULT_BITS + CODE_BITS + 7) / 8) * 8;
    localparam int OUT_PAD = OUT_W - 2 * RESULT_BITS - CODE_BITS;

    rau_cmd_t               cmd;
    rau_status_t            status;
    logic [RESULT_BITS-1:0] out_num, out_den;
    logic [CODE_BITS-1:0]   out_code;

    rau_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    rau_datapath #(
        .OPERAND_BITS(OPERAND_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_action(s_tdata[ACTION_BITS-1:0]),
        .in_a     (s_tdata[ACTION_BITS + OB - 1:ACTION_BITS]),
        .in_b     (s_tdata[ACTION_BITS + 2 * OB - 1:ACTION_BITS + OB]),
        .in_c     (s_tdata[ACTION_BITS + 3 * OB - 1:ACTION_BITS + 2 * OB]),
        .in_d     (s_tdata[ACTION_BITS + 4 * OB - 1:ACTION_BITS + 3 * OB]),
        .out_ready(m_tready),
        .out_valid(m_tvalid),
        .out_num  (out_num),
        .out_den  (out_den),
        .out_code (out_code)
    );

    assign m_tdata = {{OUT_PAD{1'b0}}, out_code, out_den, out_num};

endmodule

FILE: design/rau_div.sv
// Serial restoring divider of unsigned magnitudes, one quotient bit per cycle.
module rau_div
    import rau_pkg::*;
#(
    parameter int WIDTH = 2 * OPERAND_BITS_DEF + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_BITS = $clog2(WIDTH + 1);

    logic [WIDTH-1:0]    quo_reg, quo_next;
    logic [WIDTH-1:0]    rem_reg, rem_next;
    logic [WIDTH-1:0]    dsr_reg, dsr_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                done_reg, done_next;
    logic [WIDTH:0]      shifted;
    logic [WIDTH:0]      trial;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[WIDTH-1]};
        trial = shifted - {1'b0, dsr_reg};
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = CNT_BITS'(WIDTH);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (!trial[WIDTH])
            begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            done_next = (cnt_reg == CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: design/rau_datapath.sv
// Operand registers, shared multiplier, gcd registers and result register.
module rau_datapath
    import rau_pkg::*;
#(
    parameter int OPERAND_BITS = OPERAND_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  rau_cmd_t                      cmd,
    output rau_status_t                   status,
    input  logic [ACTION_BITS-1:0]        in_action,
    input  logic signed [OPERAND_BITS-1:0] in_a,
    input  logic signed [OPERAND_BITS-1:0] in_b,
    input  logic signed [OPERAND_BITS-1:0] in_c,
    input  logic signed [OPERAND_BITS-1:0] in_d,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [RESULT_BITS-1:0]        out_num,
    output logic [RESULT_BITS-1:0]        out_den,
    output logic [CODE_BITS-1:0]          out_code
);

    localparam int W = 2 * OPERAND_BITS + 1;
    localparam int PB = 2 * OPERAND_BITS;

    logic [ACTION_BITS-1:0]         act_reg;
    logic signed [OPERAND_BITS-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [W-1:0]            p0_reg, p1_reg, p2_reg;
    logic signed [W-1:0]            n_reg, den_reg, x_reg, y_reg;
    logic [CODE_BITS-1:0]           code_reg;
    logic                           ovalid_reg;
    logic [RESULT_BITS-1:0]         onum_reg, oden_reg;
    logic [CODE_BITS-1:0]           ocode_reg;

    logic signed [OPERAND_BITS-1:0] mx, my;
    logic signed [PB-1:0]           prod;
    logic signed [W-1:0]            form_n, form_den;
    logic [CODE_BITS-1:0]           form_code;
    logic                           form_skip;
    logic [W-1:0]                   dvd, dvs, quo, rem;
    logic                           div_busy, div_done;
    logic signed [W-1:0]            quo_s, rem_s;
    logic                           quo_neg;
    logic [63:0]                    n_wide, den_wide;

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        mag = v[W-1] ? W'(-v) : W'(v);
    endfunction

    // Shared multiplier: step 0, 1 and 2 form the three products p0, p1 and p2.
    always_comb
    begin
        case (cmd.mul_step)
            2'd0:
            begin
                mx = a_reg;
                my = (act_reg == ACT_MUL) ? c_reg : d_reg;
            end
            2'd1:
            begin
                mx = (act_reg == ACT_DIV) ? b_reg : c_reg;
                my = (act_reg == ACT_DIV) ? c_reg : b_reg;
            end
            default:
            begin
                mx = b_reg;
                my = d_reg;
            end
        endcase
        prod = mx * my;
    end

    always_comb
    begin
        form_n = '0;
        form_den = '0;
        form_code = CMP_EQUAL;
        form_skip = 1'b1;
        case (act_reg)
            ACT_ADD:
            begin
                form_n = p0_reg + p1_reg;
                form_den = p2_reg;
                form_skip = (form_n == '0) && (form_den == '0);
            end
            ACT_SUB:
            begin
                form_n = p0_reg - p1_reg;
                // A zero difference comes out as zero over zero.
                form_den = (form_n == '0) ? '0 : p2_reg;
                form_skip = (form_n == '0);
            end
            ACT_MUL:
            begin
                form_n = p0_reg;
                form_den = p2_reg;
                form_skip = (form_n == '0) && (form_den == '0);
            end
            ACT_DIV:
            begin
                form_n = p0_reg;
                form_den = p1_reg;
                form_skip = (form_n == '0) && (form_den == '0);
            end
            ACT_CMP:
            begin
                if (p0_reg == p1_reg)
                    form_code = CMP_EQUAL;
                else if (p0_reg < p1_reg)
                    form_code = CMP_LESS;
                else
                    form_code = CMP_GREATER;
            end
            default:
            begin
                form_skip = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.div_sel)
            DSEL_NUM:
            begin
                dvd = mag(n_reg);
                dvs = mag(y_reg);
            end
            DSEL_DEN:
            begin
                dvd = mag(den_reg);
                dvs = mag(y_reg);
            end
            default:
            begin
                dvd = mag(y_reg);
                dvs = mag(x_reg);
            end
        endcase
    end

    rau_div #(
        .WIDTH(W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quo),
        .remainder(rem)
    );

    // Truncating division: the remainder takes the dividend's sign.
    assign rem_s = y_reg[W-1] ? -$signed(rem) : $signed(rem);
    assign quo_neg = (cmd.num_update ? n_reg[W-1] : den_reg[W-1]) ^ y_reg[W-1];
    assign quo_s = quo_neg ? -$signed(quo) : $signed(quo);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= in_action;
            a_reg <= in_a;
            b_reg <= in_b;
            c_reg <= in_c;
            d_reg <= in_d;
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_step)
                2'd0: p0_reg <= W'(prod);
                2'd1: p1_reg <= W'(prod);
                default: p2_reg <= W'(prod);
            endcase
        end
        if (cmd.form)
        begin
            n_reg <= form_n;
            den_reg <= form_den;
            code_reg <= form_code;
            x_reg <= form_n;
            y_reg <= form_den;
        end
        if (cmd.gcd_update)
        begin
            y_reg <= x_reg;
            x_reg <= rem_s;
        end
        if (cmd.num_update)
            n_reg <= quo_s;
        if (cmd.den_update)
            den_reg <= quo_s;
    end

    assign n_wide = {{(64 - W){n_reg[W-1]}}, n_reg};
    assign den_wide = {{(64 - W){den_reg[W-1]}}, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (cmd.out_load)
            ovalid_reg <= 1'b1;
        else if (out_ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            onum_reg <= n_wide[RESULT_BITS-1:0];
            oden_reg <= den_wide[RESULT_BITS-1:0];
            ocode_reg <= code_reg;
        end
    end

    assign status.skip = form_skip;
    assign status.x_zero = (x_reg == '0);
    assign status.div_done = div_done;
    assign status.div_busy = div_busy;
    assign status.out_free = !ovalid_reg || out_ready;

    assign out_valid = ovalid_reg;
    assign out_num = onum_reg;
    assign out_den = oden_reg;
    assign out_code = ocode_reg;

endmodule

FILE: design/rau_ctrl.sv
// Controller that sequences products, gcd steps and the two final divisions.
module rau_ctrl
    import rau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  rau_status_t status,
    output rau_cmd_t    cmd
);

    rau_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_MUL0;
            ST_MUL0:      state_next = ST_MUL1;
            ST_MUL1:      state_next = ST_MUL2;
            ST_MUL2:      state_next = ST_FORM;
            ST_FORM:      state_next = status.skip ? ST_DONE : ST_GCD_CHK;
            ST_GCD_CHK:   state_next = status.x_zero ? ST_NUM_START : ST_GCD_WAIT;
            ST_GCD_WAIT:  if (status.div_done) state_next = ST_GCD_CHK;
            ST_NUM_START: state_next = ST_NUM_WAIT;
            ST_NUM_WAIT:  if (status.div_done) state_next = ST_DEN_START;
            ST_DEN_START: state_next = ST_DEN_WAIT;
            ST_DEN_WAIT:  if (status.div_done) state_next = ST_DONE;
            ST_DONE:      if (status.out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.div_sel = DSEL_GCD;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL0:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_step = 2'd0;
            end
            ST_MUL1:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_step = 2'd1;
            end
            ST_MUL2:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_step = 2'd2;
            end
            ST_FORM:      cmd.form = 1'b1;
            ST_GCD_CHK:   cmd.div_start = !status.x_zero;
            ST_GCD_WAIT:  cmd.gcd_update = status.div_done;
            ST_NUM_START:
            begin
                cmd.div_sel = DSEL_NUM;
                cmd.div_start = 1'b1;
            end
            ST_NUM_WAIT:  cmd.num_update = status.div_done;
            ST_DEN_START:
            begin
                cmd.div_sel = DSEL_DEN;
                cmd.div_start = 1'b1;
            end
            ST_DEN_WAIT:  cmd.den_update = status.div_done;
            ST_DONE:      cmd.out_load = status.out_free;
            default:      cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_MUL0))
        else $error("accepted item did not start the products");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result register overwritten");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GCD_WAIT) |-> status.div_busy || status.div_done)
        else $error("gcd step waiting on an idle divider");
`endif

endmodule
